>>> hw/rtl/sha1v_pkg.sv
// Shared types, constants and state codes for the modified SHA-1 hash block.
`default_nettype none

package sha1v_pkg;

   typedef logic [31:0] word_type;

   // Input function codes
   localparam logic FUNC_APPEND = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   // Round constants of the altered schedule
   localparam word_type K_PAR_LO = 32'h6ED9EBA1;
   localparam word_type K_MAJ    = 32'h8F1BBCDC;
   localparam word_type K_PAR_HI = 32'hCA62C1D6;

   localparam word_type INIT_CHAIN [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam int CHAIN_WORDS = 5;
   localparam int SCHED_WORDS = 16;
   localparam int ROUNDS      = 80;
   localparam int PAR_LO_END  = 20;
   localparam int MAJ_END     = 60;

   localparam int BLOCK_BYTES = 64;
   localparam int LEN_POS     = 56;
   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [7:0] PAD_ZERO = 8'h00;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WAIT_BLK,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_WAIT,
      ST_PAD_LEN,
      ST_FINAL_WAIT,
      ST_EMIT
   } state_type;

   // Sequencer to compression core
   typedef struct packed {
      logic       push;       // shift push_data into the block buffer
      logic       last;       // this byte completes the block: compress
      logic [7:0] push_data;
      logic       restart;    // reload the initial chaining words
   } ctl_type;

   // Compression core to sequencer
   typedef struct packed {
      logic busy;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/sha1v_req_if.sv
// Request channel interface: valid/ready plus function and data byte.
`default_nettype none

interface sha1v_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sha1v_rsp_if.sv
// Response channel interface: valid/ready plus one digest word beat.
`default_nettype none

interface sha1v_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sha1v_core.sv
// Compression core: byte-fed block buffer, one round per cycle, chaining words.
`default_nettype none

module sha1v_core (
   input  logic                  clock,
   input  logic                  reset,
   input  sha1v_pkg::ctl_type    ctl,
   input  logic [2:0]            rd_index,
   output sha1v_pkg::word_type   rd_word,
   output sha1v_pkg::status_type status
);

   localparam logic [6:0] LAST_ROUND = 7'(sha1v_pkg::ROUNDS - 1);
   localparam logic [6:0] SCHED_END  = 7'(sha1v_pkg::SCHED_WORDS);
   localparam logic [6:0] PAR_LO_END = 7'(sha1v_pkg::PAR_LO_END);
   localparam logic [6:0] MAJ_END    = 7'(sha1v_pkg::MAJ_END);

   // win_ff doubles as block buffer (bytes shift in) and schedule window;
   // entry 15 is the newest word.
   sha1v_pkg::word_type win_ff [sha1v_pkg::SCHED_WORDS];
   sha1v_pkg::word_type chain_ff [sha1v_pkg::CHAIN_WORDS];
   sha1v_pkg::word_type a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [6:0]          round_ff;
   logic                busy_ff;
   logic                fin_ff;

   sha1v_pkg::word_type mix;
   sha1v_pkg::word_type w_cur;
   sha1v_pkg::word_type f_cur;
   sha1v_pkg::word_type k_cur;
   sha1v_pkg::word_type t_sum;
   logic                stepping;

   assign stepping = busy_ff && !fin_ff;

   always_comb begin
      mix = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      if (round_ff < SCHED_END) begin
         w_cur = win_ff[0];
      end else begin
         w_cur = {mix[30:0], mix[31]};
      end
      if (round_ff < PAR_LO_END) begin
         f_cur = b_ff ^ c_ff ^ d_ff;
         k_cur = sha1v_pkg::K_PAR_LO;
      end else if (round_ff < MAJ_END) begin
         f_cur = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_cur = sha1v_pkg::K_MAJ;
      end else begin
         f_cur = b_ff ^ c_ff ^ d_ff;
         k_cur = sha1v_pkg::K_PAR_HI;
      end
      // shared round adder
      t_sum = {a_ff[26:0], a_ff[31:27]} + f_cur + e_ff + w_cur + k_cur;
   end

   // control and chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         fin_ff   <= 1'b0;
         round_ff <= '0;
         for (int i = 0; i < sha1v_pkg::CHAIN_WORDS; i++) begin
            chain_ff[i] <= sha1v_pkg::INIT_CHAIN[i];
         end
      end else begin
         if (ctl.push && ctl.last) begin
            busy_ff  <= 1'b1;
            round_ff <= '0;
         end else if (busy_ff) begin
            if (fin_ff) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b0;
            end else if (round_ff == LAST_ROUND) begin
               fin_ff <= 1'b1;
            end else begin
               round_ff <= round_ff + 7'd1;
            end
         end
         if (ctl.restart) begin
            for (int i = 0; i < sha1v_pkg::CHAIN_WORDS; i++) begin
               chain_ff[i] <= sha1v_pkg::INIT_CHAIN[i];
            end
         end else if (busy_ff && fin_ff) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
            chain_ff[4] <= chain_ff[4] + e_ff;
         end
      end
   end

   // buffer, schedule and working words
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         for (int i = 0; i < sha1v_pkg::SCHED_WORDS - 1; i++) begin
            win_ff[i] <= {win_ff[i][23:0], win_ff[i + 1][31:24]};
         end
         win_ff[sha1v_pkg::SCHED_WORDS - 1] <=
            {win_ff[sha1v_pkg::SCHED_WORDS - 1][23:0], ctl.push_data};
      end else if (stepping) begin
         for (int i = 0; i < sha1v_pkg::SCHED_WORDS - 1; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[sha1v_pkg::SCHED_WORDS - 1] <= w_cur;
      end
      if (ctl.push && ctl.last) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (stepping) begin
         e_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         b_ff <= a_ff;
         a_ff <= t_sum;
      end
   end

   assign rd_word     = chain_ff[rd_index];
   assign status.busy = busy_ff;

endmodule

`default_nettype wire

>>> hw/rtl/sha1v_variant_hash.sv
// Top level: byte sequencer, padding and digest output around the core.
// Append beat: the 64th byte of a block starts its compression; no request is
// taken until it ends. Finish beat: padding pushes one byte a cycle (64 - fill
// bytes, or 128 - fill, pausing for an extra compression, when the fill is 56 or
// more), then compression, then five digest beats, one per cycle when the sink is ready.
// Reset (synchronous, active high) loads the initial chaining words and clears
// the fill count, bit length and sequencer; the block buffer is not cleared.
`default_nettype none

module sha1_variant_hash (
   input  logic          clock,
   input  logic          reset,
   sha1v_req_if.sink     req_bus,
   sha1v_rsp_if.source   rsp_bus
);

   localparam logic [5:0] LAST_BYTE = 6'(sha1v_pkg::BLOCK_BYTES - 1);
   localparam logic [5:0] PRE_LEN   = 6'(sha1v_pkg::LEN_POS - 1);
   localparam logic [2:0] LAST_IDX  = 3'(sha1v_pkg::CHAIN_WORDS - 1);

   sha1v_pkg::state_type  state_ff, state_in;
   logic [5:0]            byte_count_ff, byte_count_in;   // bytes in buffer
   logic [63:0]           total_bits_ff, total_bits_in;   // message length
   logic [2:0]            idx_ff, idx_in;                 // digest word out

   sha1v_pkg::ctl_type    ctl;
   sha1v_pkg::status_type status;
   sha1v_pkg::word_type   rd_word;

   logic                  req_beat;
   logic                  rsp_beat;

   assign req_beat = req_bus.valid && req_bus.ready;
   assign rsp_beat = rsp_bus.valid && rsp_bus.ready;

   sha1v_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .rd_index (idx_ff),
      .rd_word  (rd_word),
      .status   (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sha1v_pkg::ST_IDLE;
         byte_count_ff <= '0;
         total_bits_ff <= '0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         byte_count_ff <= byte_count_in;
         total_bits_ff <= total_bits_in;
         idx_ff        <= idx_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      byte_count_in  = byte_count_ff;
      total_bits_in  = total_bits_ff;
      idx_in         = idx_ff;
      ctl            = '0;
      req_bus.ready  = 1'b0;
      rsp_bus.valid  = 1'b0;

      case (state_ff)
         sha1v_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_beat) begin
               if (req_bus.func == sha1v_pkg::FUNC_APPEND) begin
                  ctl.push      = 1'b1;
                  ctl.push_data = req_bus.data_byte;
                  ctl.last      = (byte_count_ff == LAST_BYTE);
                  byte_count_in = byte_count_ff + 6'd1;
                  total_bits_in = total_bits_ff + 64'd8;
                  if (ctl.last) begin
                     state_in = sha1v_pkg::ST_WAIT_BLK;
                  end
               end else begin
                  state_in = sha1v_pkg::ST_PAD_MARK;
               end
            end
         end

         // full block in flight; no beat until the core is done
         sha1v_pkg::ST_WAIT_BLK: begin
            if (!status.busy) begin
               state_in = sha1v_pkg::ST_IDLE;
            end
         end

         sha1v_pkg::ST_PAD_MARK: begin
            ctl.push      = 1'b1;
            ctl.push_data = sha1v_pkg::PAD_MARK;
            ctl.last      = (byte_count_ff == LAST_BYTE);
            byte_count_in = byte_count_ff + 6'd1;
            if (ctl.last) begin
               state_in = sha1v_pkg::ST_PAD_WAIT;
            end else if (byte_count_ff == PRE_LEN) begin
               state_in = sha1v_pkg::ST_PAD_LEN;
            end else begin
               state_in = sha1v_pkg::ST_PAD_ZERO;
            end
         end

         // zero fill, either up to the length field or to the end of a
         // block that has no room left for it
         sha1v_pkg::ST_PAD_ZERO: begin
            ctl.push      = 1'b1;
            ctl.push_data = sha1v_pkg::PAD_ZERO;
            ctl.last      = (byte_count_ff == LAST_BYTE);
            byte_count_in = byte_count_ff + 6'd1;
            if (ctl.last) begin
               state_in = sha1v_pkg::ST_PAD_WAIT;
            end else if (byte_count_ff == PRE_LEN) begin
               state_in = sha1v_pkg::ST_PAD_LEN;
            end
         end

         sha1v_pkg::ST_PAD_WAIT: begin
            if (!status.busy) begin
               state_in = sha1v_pkg::ST_PAD_ZERO;
            end
         end

         // length field, most significant byte first
         sha1v_pkg::ST_PAD_LEN: begin
            ctl.push      = 1'b1;
            ctl.push_data = total_bits_ff[63:56];
            ctl.last      = (byte_count_ff == LAST_BYTE);
            byte_count_in = byte_count_ff + 6'd1;
            total_bits_in = {total_bits_ff[55:0], 8'h00};
            if (ctl.last) begin
               state_in = sha1v_pkg::ST_FINAL_WAIT;
            end
         end

         sha1v_pkg::ST_FINAL_WAIT: begin
            if (!status.busy) begin
               idx_in   = '0;
               state_in = sha1v_pkg::ST_EMIT;
            end
         end

         sha1v_pkg::ST_EMIT: begin
            rsp_bus.valid = 1'b1;
            if (rsp_beat) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LAST_IDX) begin
                  ctl.restart   = 1'b1;
                  byte_count_in = '0;
                  total_bits_in = '0;
                  idx_in        = '0;
                  state_in      = sha1v_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = sha1v_pkg::ST_IDLE;
         end
      endcase
   end

   // digest words come straight from the chaining registers
   assign rsp_bus.digest_word = rd_word;
   assign rsp_bus.word_index  = idx_ff;
   assign rsp_bus.last_word   = (idx_ff == LAST_IDX);

   // A byte is never pushed while the core compresses a block.
   a_no_push_busy: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !ctl.push)
      else $error("byte pushed during compression");

   // The byte that completes a block starts the core.
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (ctl.push && ctl.last) |=> status.busy)
      else $error("block completion did not start compression");

   // No new request while a digest is being delivered.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !req_bus.ready)
      else $error("request taken during digest output");

   // After the final digest beat the message state is back at its start.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_bus.last_word) |=>
         (byte_count_ff == 6'd0 && total_bits_ff == 64'd0 && !rsp_bus.valid))
      else $error("message state not restarted after digest");

endmodule

`default_nettype wire
